@@ design/calendar_date_up_down_counter_top_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the calendar date counter
// Clocked, reset-qualified implication checks used by the top-level RTL file.
// ---------------------------------------------------------------------------
`ifndef CALENDAR_DATE_UP_DOWN_COUNTER_TOP_MACROS_SVH
`define CALENDAR_DATE_UP_DOWN_COUNTER_TOP_MACROS_SVH

// same-cycle implication
`define CDDC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("calendar date counter check failed");

// next-cycle implication
`define CDDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("calendar date counter check failed");

`endif

@@ design/cddc_pkg.sv @@
// ---------------------------------------------------------------------------
// Calendar date counter package
// Beat and date types, op codes, the reset date and the month length function.
// ---------------------------------------------------------------------------
`default_nettype none

package cddc_pkg;

	localparam logic [1:0] OP_FWD  = 2'd0;
	localparam logic [1:0] OP_BACK = 2'd1;
	localparam logic [1:0] OP_LOAD = 2'd2;

	localparam logic [4:0]  RESET_DAY   = 5'd1;
	localparam logic [3:0]  RESET_MONTH = 4'd1;
	localparam logic [15:0] RESET_YEAR  = 16'd2000;
	localparam logic [3:0]  LAST_MONTH  = 4'd12;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] load_year;
		logic [3:0]  load_month;
		logic [4:0]  load_day;
	} in_t;

	typedef struct packed {
		logic [4:0]  cur_day;
		logic [3:0]  cur_month;
		logic [15:0] cur_year;
		logic        load_rejected;
	} out_t;

	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [15:0] year;
	} date_t;

	// Days in month m of year y; zero for a month outside 1..12.
	function automatic logic [4:0] month_len(input logic [3:0] m, input logic [15:0] y);
		logic [4:0] len;
		case (m) inside
			4'd2:                                    len = (y[1:0] == 2'b00) ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:                 len = 5'd30;
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			default:                                 len = 5'd0;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

@@ design/cddc_next_date.sv @@
// ---------------------------------------------------------------------------
// Calendar date next-state logic
// Steps the date one day either way, checks and applies a load, or holds.
// ---------------------------------------------------------------------------
`default_nettype none

module cddc_next_date (
	input  cddc_pkg::date_t cur,
	input  cddc_pkg::in_t   item,
	output cddc_pkg::date_t nxt,
	output logic            rejected
);
	import cddc_pkg::*;

	logic [4:0] cur_len;
	logic [3:0] back_month;
	logic [15:0] back_year;
	logic [4:0] load_len;

	assign cur_len  = month_len(cur.month, cur.year);
	assign load_len = month_len(item.load_month, item.load_year);

	// month/year after backing out of the first day of a month
	always_comb begin
		if (cur.month <= 4'd1) begin
			back_month = LAST_MONTH;
			back_year  = cur.year - 16'd1;
		end else begin
			back_month = cur.month - 4'd1;
			back_year  = cur.year;
		end
	end

	always_comb begin
		nxt      = cur;
		rejected = 1'b0;
		case (item.op)
			OP_FWD: begin
				if (cur.day >= cur_len) begin
					nxt.day = 5'd1;
					if (cur.month >= LAST_MONTH) begin
						nxt.month = 4'd1;
						nxt.year  = cur.year + 16'd1;
					end else begin
						nxt.month = cur.month + 4'd1;
					end
				end else begin
					nxt.day = cur.day + 5'd1;
				end
			end
			OP_BACK: begin
				if (cur.day <= 5'd1) begin
					nxt.month = back_month;
					nxt.year  = back_year;
					nxt.day   = month_len(back_month, back_year);
				end else begin
					nxt.day = cur.day - 5'd1;
				end
			end
			OP_LOAD: begin
				if (load_len == 5'd0 || item.load_day == 5'd0 || item.load_day > load_len) begin
					rejected = 1'b1;
				end else begin
					nxt.day   = item.load_day;
					nxt.month = item.load_month;
					nxt.year  = item.load_year;
				end
			end
			default: begin
				// unused op: hold the date
				nxt = cur;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ design/calendar_date_up_down_counter_top.sv @@
// ---------------------------------------------------------------------------
// Calendar date up/down counter
// Keeps a day/month/year that steps one day forward or back, or loads.
// ---------------------------------------------------------------------------
//  channel | ports                          | beat
//  --------+--------------------------------+------------------------------
//  in      | in_valid, in_ready, in_data    | op, load_year/month/day
//  out     | out_valid, out_ready, out_data | cur_day/month/year, rejected
//
//  One beat in per cycle while out_ready stays high; each beat gives one result beat.
//  Each beat passes the input register, then the next-date logic feeds
//  the date register and the result register together.
//  Reset sets the date to 1/1/2000 and empties both registers.
//  A stalled output holds the input register; in_ready drops only when
//  both registers are full and out_ready is low.
// ---------------------------------------------------------------------------
`default_nettype none
`include "calendar_date_up_down_counter_top_macros.svh"

module calendar_date_up_down_counter_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  cddc_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output cddc_pkg::out_t out_data
);
	import cddc_pkg::*;

	logic  valid_s1;
	in_t   item_s1;
	date_t date_q;
	date_t date_nxt;
	logic  rejected;
	logic  advance;
	logic  valid_s2;
	out_t  result_s2;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	cddc_next_date u_next (
		.cur      (date_q),
		.item     (item_s1),
		.nxt      (date_nxt),
		.rejected (rejected)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			date_q <= '{day: RESET_DAY, month: RESET_MONTH, year: RESET_YEAR};
		end else if (advance) begin
			date_q <= date_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= '{cur_day: date_nxt.day, cur_month: date_nxt.month,
				cur_year: date_nxt.year, load_rejected: rejected};
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = result_s2;

	`CDDC_ASSERT_NOW(a_date_legal, clk, arst_n, 1'b1,
		date_q.month >= 4'd1 && date_q.month <= LAST_MONTH && date_q.day >= 5'd1
		&& date_q.day <= month_len(date_q.month, date_q.year))
	`CDDC_ASSERT_NOW(a_out_tracks_date, clk, arst_n, valid_s2,
		out_data.cur_day == date_q.day && out_data.cur_month == date_q.month
		&& out_data.cur_year == date_q.year)
	`CDDC_ASSERT_NEXT(a_hold_s1, clk, arst_n, valid_s1 && !advance,
		valid_s1 && $stable(item_s1))
	`CDDC_ASSERT_NEXT(a_step_no_reject, clk, arst_n, advance && item_s1.op != OP_LOAD,
		!out_data.load_rejected)

endmodule

`default_nettype wire
